@@ rtl/wtts_pkg.sv @@
// Shared types, codes and constants for the weld torch trigger sequencer.
// No dependencies; used by every module under rtl/.
package wtts_pkg;

    // Default width of the elapsed tick counter
    localparam int TICK_COUNT_BITS_DEF = 12;

    // Field widths
    localparam int WIRE_W    = 12;
    localparam int RATE_W    = 7;
    localparam int TIME_W    = 8;
    localparam int PROD_W    = WIRE_W + RATE_W;
    localparam int REF_W     = 12;
    localparam int CNT_W     = 12;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 40;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_PRE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WELD = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BURN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_POST = 3'd3;
    localparam logic [PHASE_W-1:0] PH_EXIT = 3'd4;

    // Output flag bit positions
    localparam int FL_GAS      = 0;
    localparam int FL_PULSE    = 1;
    localparam int FL_CVREF    = 2;
    localparam int FL_FORCEOFF = 3;
    localparam int FL_MSTOP    = 4;
    localparam int FL_ENDSTOP  = 5;
    localparam int FL_CRATER   = 6;
    localparam int FLAG_W      = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFLOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURNBACK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTFLOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CREEP_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CREEP_TIME   = 3'd5;

    // Trigger modes
    localparam logic MODE_2T = 1'b0;
    localparam logic MODE_4T = 1'b1;

    // Beat kinds carried on the slave tuser
    localparam logic CMD_EVAL = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Divide by 100: q = (p * RECIP) >> SHIFT, exact for p < 2^19
    localparam int                RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] CREEP_RECIP = 20'd671089;
    localparam int                CREEP_SHIFT = 26;
    localparam int                QUOT_W      = PROD_W + RECIP_W - CREEP_SHIFT;
    localparam logic [REF_W-1:0]  REF_MAX     = '1;

    typedef struct packed {
        logic              trigger_mode;
        logic [TIME_W-1:0] preflow_time;
        logic [TIME_W-1:0] burnback_time;
        logic [TIME_W-1:0] postflow_time;
        logic [RATE_W-1:0] creep_rate_percent;
        logic [TIME_W-1:0] creep_time;
    } t_cfg;

    // Registered input beat; creep product precomputed
    typedef struct packed {
        logic              cmd;
        logic              torch_pressed;
        logic              gas_mode_selected;
        logic              global_error;
        logic [PROD_W-1:0] creep_prod;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [FLAG_W-1:0]  flags;
        logic               cycle_active;
        logic               reference_valid;
        logic [REF_W-1:0]   reference_value;
        logic [CNT_W-1:0]   creep_down_count;
    } t_result;

endpackage

@@ rtl/weld_torch_trigger_sequencer_unit.sv @@
// Top level of the weld torch trigger sequencer (2T / 4T with crater).
// Depends on wtts_pkg, wtts_cfg_regs, wtts_in_stage, wtts_seq_core.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  s stream  | in        | i_s_tvalid/o_s_tready  | tdata: trigger beat, tuser: cmd
//  m stream  | out       | o_m_tvalid/i_m_tready  | tdata: outputs, tuser: ref valid
//  cfg write | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Every beat gives one result beat. A beat is held in the input register
// (wire speed times creep rate is formed there), then the phase machine and
// divide-by-100 update state and the result register; one beat per cycle
// is sustained while the master side is ready. Reset is synchronous; it loads
// the configuration defaults and puts the phase at exit. A stalled result
// holds the input register, which then holds the slave side.
module weld_torch_trigger_sequencer_unit #(
    parameter int TICK_COUNT_BITS = wtts_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: torch_pressed[0], gas_mode_selected[1], global_error[2],
    //        wire_speed[14:3], zero[15]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wtts_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: cmd[0]
    input  logic                            i_s_tuser,
    // tdata: phase[2:0], gas_valve_on[3], pulse_start[4], cv_reference_on[5],
    //        force_output_off[6], motor_stop[7], end_pulse_stop[8],
    //        crater_active[9], cycle_active[10], reference_value[22:11],
    //        creep_down_count[34:23], zero[39:35]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wtts_pkg::M_DATA_W-1:0]   o_m_tdata,
    // tuser: reference_valid[0]
    output logic                            o_m_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wtts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtts_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    wtts_pkg::t_cfg    w_cfg;
    wtts_pkg::t_item   w_item;
    wtts_pkg::t_result w_result;
    logic              w_item_valid;
    logic              w_take;

    wtts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wtts_in_stage u_in (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_s_tvalid),
        .o_ready             (o_s_tready),
        .i_cmd               (i_s_tuser),
        .i_torch_pressed     (i_s_tdata[0]),
        .i_gas_mode_selected (i_s_tdata[1]),
        .i_global_error      (i_s_tdata[2]),
        .i_wire_speed        (i_s_tdata[14:3]),
        .i_creep_rate        (w_cfg.creep_rate_percent),
        .i_take              (w_take),
        .o_valid             (w_item_valid),
        .o_item              (w_item)
    );

    wtts_seq_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    // Pack the result beat
    assign o_m_tdata = {5'd0,
                        w_result.creep_down_count,
                        w_result.reference_value,
                        w_result.cycle_active,
                        w_result.flags[wtts_pkg::FL_CRATER],
                        w_result.flags[wtts_pkg::FL_ENDSTOP],
                        w_result.flags[wtts_pkg::FL_MSTOP],
                        w_result.flags[wtts_pkg::FL_FORCEOFF],
                        w_result.flags[wtts_pkg::FL_CVREF],
                        w_result.flags[wtts_pkg::FL_PULSE],
                        w_result.flags[wtts_pkg::FL_GAS],
                        w_result.phase};
    assign o_m_tuser = w_result.reference_valid;

    // Weld enable and burnback reference are never driven together
    a_pulse_cvref_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[4] && o_m_tdata[5]))
        else $error("pulse_start and cv_reference_on both set");

    // An unissued reference reads as zero
    a_ref_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[22:11] == '0))
        else $error("reference_value nonzero without reference_valid");

    // Creep count only comes with the weld-start beat
    a_creep_weld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[34:23] != '0)
            |-> (o_m_tdata[2:0] == wtts_pkg::PH_WELD && o_m_tuser))
        else $error("creep_down_count outside weld start");

endmodule

@@ rtl/wtts_cfg_regs.sv @@
// Configuration register file for the trigger sequencer.
// Depends on wtts_pkg.
module wtts_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wtts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wtts_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output wtts_pkg::t_cfg                o_cfg
);

    wtts_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_mode       <= 1'b0;
            r_cfg.preflow_time       <= 8'd5;
            r_cfg.burnback_time      <= 8'd10;
            r_cfg.postflow_time      <= 8'd5;
            r_cfg.creep_rate_percent <= 7'd50;
            r_cfg.creep_time         <= 8'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wtts_pkg::CFG_TRIGGER_MODE: r_cfg.trigger_mode <= i_cfg_data[0];
                wtts_pkg::CFG_PREFLOW:      r_cfg.preflow_time <= i_cfg_data;
                wtts_pkg::CFG_BURNBACK:     r_cfg.burnback_time <= i_cfg_data;
                wtts_pkg::CFG_POSTFLOW:     r_cfg.postflow_time <= i_cfg_data;
                wtts_pkg::CFG_CREEP_RATE:
                    r_cfg.creep_rate_percent <= i_cfg_data[wtts_pkg::RATE_W-1:0];
                wtts_pkg::CFG_CREEP_TIME:   r_cfg.creep_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/wtts_in_stage.sv @@
// Input register stage: captures one beat and forms wire_speed * creep rate.
// Depends on wtts_pkg.
module wtts_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic                           i_torch_pressed,
    input  logic                           i_gas_mode_selected,
    input  logic                           i_global_error,
    input  logic [wtts_pkg::WIRE_W-1:0]    i_wire_speed,
    input  logic [wtts_pkg::RATE_W-1:0]    i_creep_rate,
    input  logic                           i_take,
    output logic                           o_valid,
    output wtts_pkg::t_item                o_item
);

    logic            r_valid;
    wtts_pkg::t_item r_item;
    logic            w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload; the product is registered before the divide-by-100 stage
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd               <= i_cmd;
            r_item.torch_pressed     <= i_torch_pressed;
            r_item.gas_mode_selected <= i_gas_mode_selected;
            r_item.global_error      <= i_global_error;
            r_item.creep_prod        <= wtts_pkg::PROD_W'(i_wire_speed)
                                        * wtts_pkg::PROD_W'(i_creep_rate);
        end
    end

endmodule

@@ rtl/wtts_seq_core.sv @@
// Trigger phase machine, tick counter and result register.
// Depends on wtts_pkg.
module wtts_seq_core #(
    parameter int TICK_COUNT_BITS = wtts_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wtts_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  wtts_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_valid,
    input  logic            i_ready,
    output wtts_pkg::t_result o_result
);

    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    // Sequencer state
    logic [wtts_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                         r_cycle, n_cycle;
    logic                         r_timer, n_timer;
    logic [TICK_COUNT_BITS-1:0]   r_elapsed, n_elapsed;
    logic                         r_released, n_released;
    logic                         r_crater_set, n_crater_set;
    logic                         r_rel_seen, n_rel_seen;
    logic [wtts_pkg::FLAG_W-1:0]  r_flags, n_flags;

    logic                         r_out_valid;
    wtts_pkg::t_result            r_result;

    logic                         n_ref_issued;
    logic [wtts_pkg::REF_W-1:0]   n_ref_val;
    logic [wtts_pkg::CNT_W-1:0]   n_creep_cnt;

    logic [TICK_COUNT_BITS-1:0]   w_pre_lim, w_burn_lim, w_post_lim;
    logic [wtts_pkg::CNT_W-1:0]   w_creep_cnt;
    logic [wtts_pkg::PROD_W+wtts_pkg::RECIP_W-1:0] w_recip_prod;
    logic [wtts_pkg::QUOT_W-1:0]  w_quot;
    logic [wtts_pkg::REF_W-1:0]   w_creep_ref;
    logic                         w_press;

    assign o_take   = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;
    assign w_press  = i_item.torch_pressed;

    // Limits: ten times the flow times, burnback as is
    assign w_pre_lim   = TICK_COUNT_BITS'({4'd0, i_cfg.preflow_time, 3'd0})
                       + TICK_COUNT_BITS'({4'd0, i_cfg.preflow_time, 1'b0});
    assign w_post_lim  = TICK_COUNT_BITS'({4'd0, i_cfg.postflow_time, 3'd0})
                       + TICK_COUNT_BITS'({4'd0, i_cfg.postflow_time, 1'b0});
    assign w_burn_lim  = TICK_COUNT_BITS'(i_cfg.burnback_time);
    assign w_creep_cnt = wtts_pkg::CNT_W'({i_cfg.creep_time, 3'd0})
                       + wtts_pkg::CNT_W'({i_cfg.creep_time, 1'b0});

    // Creep reference: product / 100 by reciprocal, then clamp
    assign w_recip_prod = (wtts_pkg::PROD_W + wtts_pkg::RECIP_W)'(i_item.creep_prod)
                        * (wtts_pkg::PROD_W + wtts_pkg::RECIP_W)'(wtts_pkg::CREEP_RECIP);
    assign w_quot       = w_recip_prod[wtts_pkg::PROD_W+wtts_pkg::RECIP_W-1:
                                       wtts_pkg::CREEP_SHIFT];
    assign w_creep_ref  = (w_quot > wtts_pkg::QUOT_W'(wtts_pkg::REF_MAX))
                        ? wtts_pkg::REF_MAX : w_quot[wtts_pkg::REF_W-1:0];

    // Next state for one beat; updates apply in program order
    always_comb begin
        n_phase      = r_phase;
        n_cycle      = r_cycle;
        n_timer      = r_timer;
        n_elapsed    = r_elapsed;
        n_released   = r_released;
        n_crater_set = r_crater_set;
        n_rel_seen   = r_rel_seen;
        n_flags      = r_flags;
        n_ref_issued = 1'b0;
        n_ref_val    = '0;
        n_creep_cnt  = '0;

        if (i_item.cmd == wtts_pkg::CMD_TICK) begin
            // Timer tick, saturating
            if (r_timer && r_elapsed != TICK_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end else if (w_press || r_cycle) begin
            if (i_item.gas_mode_selected && !i_item.global_error) begin
                if (!r_cycle) begin
                    n_phase = wtts_pkg::PH_PRE;
                end
                if (i_cfg.trigger_mode == wtts_pkg::MODE_2T) begin
                    // Two-step
                    unique case (n_phase)
                        wtts_pkg::PH_PRE: begin
                            n_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                            if (!n_cycle) begin
                                n_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_flags[wtts_pkg::FL_MSTOP] = 1'b1;
                                n_timer   = 1'b1;
                                n_elapsed = '0;
                                n_cycle   = 1'b1;
                            end
                            if (n_elapsed >= w_pre_lim) begin
                                n_timer   = 1'b0;
                                n_elapsed = '0;
                                n_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_flags[wtts_pkg::FL_PULSE] = 1'b1;
                                n_flags[wtts_pkg::FL_MSTOP] = 1'b0;
                                n_phase = wtts_pkg::PH_WELD;
                            end
                            if (!w_press) n_phase = wtts_pkg::PH_EXIT;
                        end
                        wtts_pkg::PH_WELD: begin
                            n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                            n_flags[wtts_pkg::FL_PULSE] = 1'b1;
                            if (!w_press) begin
                                n_timer   = 1'b1;
                                n_elapsed = '0;
                                n_flags[wtts_pkg::FL_PULSE]   = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF]   = 1'b1;
                                n_flags[wtts_pkg::FL_ENDSTOP] = 1'b1;
                                n_phase = wtts_pkg::PH_BURN;
                            end
                        end
                        wtts_pkg::PH_BURN: begin
                            if (n_elapsed >= w_burn_lim) begin
                                n_timer   = 1'b1;
                                n_elapsed = '0;
                                n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b1;
                                n_phase = wtts_pkg::PH_POST;
                            end
                            if (w_press) n_phase = wtts_pkg::PH_EXIT;
                        end
                        wtts_pkg::PH_POST: begin
                            n_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                            n_flags[wtts_pkg::FL_MSTOP]    = 1'b1;
                            if (n_elapsed >= w_post_lim) begin
                                n_flags[wtts_pkg::FL_GAS]   = 1'b0;
                                n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_timer   = 1'b0;
                                n_elapsed = '0;
                                n_phase   = wtts_pkg::PH_EXIT;
                            end
                            if (w_press) n_phase = wtts_pkg::PH_EXIT;
                        end
                        default: begin
                            n_timer   = 1'b0;
                            n_elapsed = '0;
                            n_cycle   = 1'b0;
                            n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                            n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                            n_phase   = wtts_pkg::PH_EXIT;
                        end
                    endcase
                end else begin
                    // Four-step with crater
                    unique case (n_phase)
                        wtts_pkg::PH_PRE: begin
                            n_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                            if (!n_cycle) begin
                                n_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_timer   = 1'b1;
                                n_elapsed = '0;
                                n_cycle   = 1'b1;
                            end else if (n_elapsed >= w_pre_lim && !w_press) begin
                                n_timer   = 1'b0;
                                n_elapsed = '0;
                                n_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_flags[wtts_pkg::FL_PULSE] = 1'b1;
                                n_flags[wtts_pkg::FL_MSTOP] = 1'b0;
                                n_ref_val    = w_creep_ref;
                                n_ref_issued = 1'b1;
                                n_creep_cnt  = w_creep_cnt;
                                n_phase      = wtts_pkg::PH_WELD;
                            end
                        end
                        wtts_pkg::PH_WELD: begin
                            if (!n_released) begin
                                if (w_press) begin
                                    n_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                                end else begin
                                    n_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                                    n_released = 1'b1;
                                end
                            end else if (!n_crater_set) begin
                                if (w_press) begin
                                    n_flags[wtts_pkg::FL_CRATER] = 1'b1;
                                    n_crater_set = 1'b1;
                                end
                            end else if (!w_press) begin
                                n_timer   = 1'b1;
                                n_elapsed = '0;
                                n_flags[wtts_pkg::FL_PULSE]   = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF]   = 1'b1;
                                n_flags[wtts_pkg::FL_ENDSTOP] = 1'b1;
                                n_flags[wtts_pkg::FL_CRATER]  = 1'b0;
                                n_phase = wtts_pkg::PH_BURN;
                            end
                        end
                        wtts_pkg::PH_BURN: begin
                            if (n_elapsed >= w_burn_lim) begin
                                n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b1;
                                n_timer      = 1'b1;
                                n_elapsed    = '0;
                                n_crater_set = 1'b0;
                                n_phase      = wtts_pkg::PH_POST;
                            end
                            // Press after a release aborts
                            if (!w_press && !n_rel_seen) n_rel_seen = 1'b1;
                            else if (w_press && n_rel_seen) n_phase = wtts_pkg::PH_EXIT;
                        end
                        wtts_pkg::PH_POST: begin
                            n_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                            n_flags[wtts_pkg::FL_MSTOP]    = 1'b1;
                            if (n_elapsed >= w_post_lim) begin
                                n_flags[wtts_pkg::FL_GAS]   = 1'b0;
                                n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_timer   = 1'b0;
                                n_elapsed = '0;
                                n_phase   = wtts_pkg::PH_EXIT;
                            end
                            if (!w_press && !n_rel_seen) n_rel_seen = 1'b1;
                            else if (w_press && n_rel_seen) n_phase = wtts_pkg::PH_EXIT;
                        end
                        default: begin
                            n_phase = wtts_pkg::PH_EXIT;
                            if (!w_press) begin
                                n_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                n_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                n_timer      = 1'b0;
                                n_elapsed    = '0;
                                n_cycle      = 1'b0;
                                n_released   = 1'b0;
                                n_rel_seen   = 1'b0;
                                n_crater_set = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end else if (i_item.global_error) begin
            // Idle with error: issue a zero reference
            n_ref_issued = 1'b1;
        end
    end

    // State update, one beat per cycle while the result side is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wtts_pkg::PH_EXIT;
            r_cycle      <= 1'b0;
            r_timer      <= 1'b0;
            r_elapsed    <= '0;
            r_released   <= 1'b0;
            r_crater_set <= 1'b0;
            r_rel_seen   <= 1'b0;
            r_flags      <= '0;
        end else if (o_take) begin
            r_phase      <= n_phase;
            r_cycle      <= n_cycle;
            r_timer      <= n_timer;
            r_elapsed    <= n_elapsed;
            r_released   <= n_released;
            r_crater_set <= n_crater_set;
            r_rel_seen   <= n_rel_seen;
            r_flags      <= n_flags;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result.phase            <= n_phase;
            r_result.flags            <= n_flags;
            r_result.cycle_active     <= n_cycle;
            r_result.reference_valid  <= n_ref_issued;
            r_result.reference_value  <= n_ref_val;
            r_result.creep_down_count <= n_creep_cnt;
        end
    end

endmodule

@@ test/weld_torch_trigger_sequencer_unit_test.sv @@
// Self-checking bench for weld_torch_trigger_sequencer_unit: directed table then random traffic,
// each result beat checked per field against a typed want or a cycle-free sequencer predictor.
// Depends on wtts_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module weld_torch_trigger_sequencer_unit_test;

    // Register indexes with no register behind them
    localparam logic [wtts_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [wtts_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RAND_PHASES    = 8;
    localparam int BEATS_PER_PHASE = 190;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [wtts_pkg::CFG_IDX_W-1:0]   idx;
        logic [wtts_pkg::CFG_DAT_W-1:0]   data;
        logic                             cmd;
        logic                             pressed;
        logic                             gas;
        logic                             gerr;
        logic [wtts_pkg::WIRE_W-1:0]      wspd;
        logic [12:0]                      reps;
        logic                             typed;
        wtts_pkg::t_result                want;
    } t_stim_row;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [wtts_pkg::S_DATA_W-1:0]  i_s_tdata   = '0;
    logic                           i_s_tuser   = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [wtts_pkg::M_DATA_W-1:0]  o_m_tdata;
    logic                           o_m_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [wtts_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [wtts_pkg::CFG_DAT_W-1:0] i_cfg_data  = '0;

    weld_torch_trigger_sequencer_unit u_top (.*);

    // Predictor state, reset values
    wtts_pkg::t_cfg mdl_cfg = '{trigger_mode: wtts_pkg::MODE_2T, preflow_time: 8'd5,
                                burnback_time: 8'd10, postflow_time: 8'd5,
                                creep_rate_percent: 7'd50, creep_time: 8'd5};
    logic [wtts_pkg::PHASE_W-1:0]             sq_phase    = wtts_pkg::PH_EXIT;
    logic                                     sq_started  = 1'b0;
    logic                                     sq_timer    = 1'b0;
    logic                                     sq_released = 1'b0;
    logic                                     sq_crater   = 1'b0;
    logic                                     sq_rel_seen = 1'b0;
    logic [wtts_pkg::TICK_COUNT_BITS_DEF-1:0] sq_elapsed  = '0;
    logic [wtts_pkg::FLAG_W-1:0]              sq_flags    = '0;

    wtts_pkg::t_result pending_q[$];
    t_stim_row         dir_tab[$];
    int                n_fail   = 0;
    bit                src_calm = 1'b0;
    bit                snk_calm = 1'b0;

    string flag_name[wtts_pkg::FLAG_W] = '{"gas_valve_on", "pulse_start", "cv_reference_on",
                                           "force_output_off", "motor_stop",
                                           "end_pulse_stop", "crater_active"};

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer predictor
    // ------------------------------------------------------------------
    function automatic void rearm_timer(logic run);
        sq_timer   = run;
        sq_elapsed = '0;
    endfunction

    // 4T: a press after a release in burnback / postflow aborts
    function automatic void check_abort(logic pressed);
        if (!pressed && !sq_rel_seen) sq_rel_seen = 1'b1;
        else if (pressed && sq_rel_seen) sq_phase = wtts_pkg::PH_EXIT;
    endfunction

    function automatic wtts_pkg::t_result step_sequencer(logic cmd, logic pressed,
                                                         logic gas, logic gerr,
                                                         logic [wtts_pkg::WIRE_W-1:0] wspd);
        wtts_pkg::t_result res;
        int                creep;
        res = '0;
        if (cmd == wtts_pkg::CMD_TICK) begin
            if (sq_timer && sq_elapsed != '1) sq_elapsed = sq_elapsed + 1'b1;
        end else if (pressed || sq_started) begin
            if (gas && !gerr) begin
                if (!sq_started) sq_phase = wtts_pkg::PH_PRE;
                if (mdl_cfg.trigger_mode == wtts_pkg::MODE_2T) begin
                    case (sq_phase)
                        wtts_pkg::PH_PRE: begin
                            sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                            if (!sq_started) begin
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                sq_flags[wtts_pkg::FL_MSTOP] = 1'b1;
                                rearm_timer(1'b1);
                                sq_started = 1'b1;
                            end
                            if (sq_elapsed >= 10 * mdl_cfg.preflow_time) begin
                                rearm_timer(1'b0);
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b1;
                                sq_flags[wtts_pkg::FL_MSTOP] = 1'b0;
                                sq_phase = wtts_pkg::PH_WELD;
                            end
                            // release in preflow leaves the gas valve as it is
                            if (!pressed) sq_phase = wtts_pkg::PH_EXIT;
                        end
                        wtts_pkg::PH_WELD: begin
                            sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                            sq_flags[wtts_pkg::FL_PULSE] = 1'b1;
                            if (!pressed) begin
                                rearm_timer(1'b1);
                                sq_flags[wtts_pkg::FL_PULSE]   = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF]   = 1'b1;
                                sq_flags[wtts_pkg::FL_ENDSTOP] = 1'b1;
                                sq_phase = wtts_pkg::PH_BURN;
                            end
                        end
                        wtts_pkg::PH_BURN: begin
                            if (sq_elapsed >= mdl_cfg.burnback_time) begin
                                rearm_timer(1'b1);
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b1;
                                sq_phase = wtts_pkg::PH_POST;
                            end
                            if (pressed) sq_phase = wtts_pkg::PH_EXIT;
                        end
                        wtts_pkg::PH_POST: begin
                            sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                            sq_flags[wtts_pkg::FL_MSTOP]    = 1'b1;
                            if (sq_elapsed >= 10 * mdl_cfg.postflow_time) begin
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b0;
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                rearm_timer(1'b0);
                                sq_phase = wtts_pkg::PH_EXIT;
                            end
                            if (pressed) sq_phase = wtts_pkg::PH_EXIT;
                        end
                        default: begin
                            rearm_timer(1'b0);
                            sq_started = 1'b0;
                            sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                            sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                            sq_phase = wtts_pkg::PH_EXIT;
                        end
                    endcase
                end else begin
                    case (sq_phase)
                        wtts_pkg::PH_PRE: begin
                            sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                            if (!sq_started) begin
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                rearm_timer(1'b1);
                                sq_started = 1'b1;
                            end else if (sq_elapsed >= 10 * mdl_cfg.preflow_time
                                         && !pressed) begin
                                rearm_timer(1'b0);
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b1;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b1;
                                sq_flags[wtts_pkg::FL_MSTOP] = 1'b0;
                                // creep reference, saturated to the field
                                creep = int'(wspd) * int'(mdl_cfg.creep_rate_percent) / 100;
                                res.reference_valid  = 1'b1;
                                res.reference_value  = (creep > int'(wtts_pkg::REF_MAX)) ?
                                                       wtts_pkg::REF_MAX :
                                                       wtts_pkg::REF_W'(creep);
                                res.creep_down_count = wtts_pkg::CNT_W'(10 * mdl_cfg.creep_time);
                                sq_phase = wtts_pkg::PH_WELD;
                            end
                        end
                        wtts_pkg::PH_WELD: begin
                            if (!sq_released) begin
                                if (pressed) sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                                else begin
                                    sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b0;
                                    sq_released = 1'b1;
                                end
                            end else if (!sq_crater) begin
                                if (pressed) begin
                                    sq_flags[wtts_pkg::FL_CRATER] = 1'b1;
                                    sq_crater = 1'b1;
                                end
                            end else if (!pressed) begin
                                rearm_timer(1'b1);
                                sq_flags[wtts_pkg::FL_PULSE]   = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF]   = 1'b1;
                                sq_flags[wtts_pkg::FL_ENDSTOP] = 1'b1;
                                sq_flags[wtts_pkg::FL_CRATER]  = 1'b0;
                                sq_phase = wtts_pkg::PH_BURN;
                            end
                        end
                        wtts_pkg::PH_BURN: begin
                            if (sq_elapsed >= mdl_cfg.burnback_time) begin
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b1;
                                rearm_timer(1'b1);
                                sq_crater = 1'b0;
                                sq_phase = wtts_pkg::PH_POST;
                            end
                            check_abort(pressed);
                        end
                        wtts_pkg::PH_POST: begin
                            sq_flags[wtts_pkg::FL_FORCEOFF] = 1'b1;
                            sq_flags[wtts_pkg::FL_MSTOP]    = 1'b1;
                            if (sq_elapsed >= 10 * mdl_cfg.postflow_time) begin
                                sq_flags[wtts_pkg::FL_GAS]   = 1'b0;
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                rearm_timer(1'b0);
                                sq_phase = wtts_pkg::PH_EXIT;
                            end
                            check_abort(pressed);
                        end
                        default: begin
                            sq_phase = wtts_pkg::PH_EXIT;
                            if (!pressed) begin
                                sq_flags[wtts_pkg::FL_PULSE] = 1'b0;
                                sq_flags[wtts_pkg::FL_CVREF] = 1'b0;
                                rearm_timer(1'b0);
                                sq_started  = 1'b0;
                                sq_released = 1'b0;
                                sq_rel_seen = 1'b0;
                                sq_crater   = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end else if (gerr) begin
            // idle machine with global error: zero reference issued
            res.reference_valid = 1'b1;
        end
        res.phase        = sq_phase;
        res.flags        = sq_flags;
        res.cycle_active = sq_started;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // tdata: phase[2:0], flags[9:3], cycle_active[10], reference_value[22:11],
    //        creep_down_count[34:23], zero[39:35]; tuser: reference_valid
    function automatic void check_result(logic [wtts_pkg::M_DATA_W-1:0] tdata, logic tuser);
        wtts_pkg::t_result want;
        if (pending_q.size() == 0) begin
            $error("result beat with no expectation pending");
            n_fail++;
            return;
        end
        want = pending_q.pop_front();
        check_field("phase", want.phase, tdata[2:0]);
        for (int f = 0; f < wtts_pkg::FLAG_W; f++)
            check_field(flag_name[f], want.flags[f], tdata[3+f]);
        check_field("cycle_active", want.cycle_active, tdata[10]);
        check_field("reference_valid", want.reference_valid, tuser);
        check_field("reference_value", want.reference_value, tdata[22:11]);
        check_field("creep_down_count", want.creep_down_count, tdata[34:23]);
        check_field("tdata_pad", 0, tdata[39:35]);
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Result side: random stall per beat
    initial begin : result_sink
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(snk_calm);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (o_m_tvalid !== 1'b1) @(posedge i_clk);
            check_result(o_m_tdata, o_m_tuser);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(logic cmd, logic pressed, logic gas, logic gerr,
                             logic [wtts_pkg::WIRE_W-1:0] wspd, logic typed,
                             wtts_pkg::t_result want);
        int                gap;
        wtts_pkg::t_result got;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, wspd, gerr, gas, pressed};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        got = step_sequencer(cmd, pressed, gas, gerr, wspd);
        pending_q.push_back(typed ? want : got);
    endtask

    // Called right after a beat was accepted: drop valid, wait for the block to empty
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Valid stays high across a batch of writes; the last write of a batch drops it
    task automatic write_reg(logic [wtts_pkg::CFG_IDX_W-1:0] idx,
                             logic [wtts_pkg::CFG_DAT_W-1:0] data, logic last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (last) i_cfg_valid <= 1'b0;
        case (idx)
            wtts_pkg::CFG_TRIGGER_MODE: mdl_cfg.trigger_mode  = data[0];
            wtts_pkg::CFG_PREFLOW:      mdl_cfg.preflow_time  = data;
            wtts_pkg::CFG_BURNBACK:     mdl_cfg.burnback_time = data;
            wtts_pkg::CFG_POSTFLOW:     mdl_cfg.postflow_time = data;
            wtts_pkg::CFG_CREEP_RATE:
                mdl_cfg.creep_rate_percent = data[wtts_pkg::RATE_W-1:0];
            wtts_pkg::CFG_CREEP_TIME:   mdl_cfg.creep_time    = data;
            default: ;
        endcase
    endtask

    function automatic wtts_pkg::t_result mk_want(logic [wtts_pkg::PHASE_W-1:0] ph,
                                                  logic [wtts_pkg::FLAG_W-1:0] fl,
                                                  logic cyc, logic rv,
                                                  logic [wtts_pkg::REF_W-1:0] val,
                                                  logic [wtts_pkg::CNT_W-1:0] cnt);
        wtts_pkg::t_result r;
        r.phase            = ph;
        r.flags            = fl;
        r.cycle_active     = cyc;
        r.reference_valid  = rv;
        r.reference_value  = val;
        r.creep_down_count = cnt;
        return r;
    endfunction

    function automatic void put_reg(logic [wtts_pkg::CFG_IDX_W-1:0] idx,
                                    logic [wtts_pkg::CFG_DAT_W-1:0] data);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        dir_tab.push_back(row);
    endfunction

    function automatic void put_beat(logic cmd, logic pressed, logic gas, logic gerr,
                                     logic [wtts_pkg::WIRE_W-1:0] wspd, int reps = 1,
                                     logic typed = 1'b0, wtts_pkg::t_result want = '0);
        t_stim_row row;
        row         = '0;
        row.kind    = ROW_BEAT;
        row.cmd     = cmd;
        row.pressed = pressed;
        row.gas     = gas;
        row.gerr    = gerr;
        row.wspd    = wspd;
        row.reps    = 13'(reps);
        row.typed   = typed;
        row.want    = want;
        dir_tab.push_back(row);
    endfunction

    function automatic logic [7:0] pick_flow_time();
        case ($urandom_range(0, 15))
            0, 1:    return 8'd0;
            2:       return 8'hFF;
            default: return 8'($urandom_range(1, 3));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        wtts_pkg::t_result           idle_out;
        logic                        torch;
        logic                        cmd;
        logic [wtts_pkg::WIRE_W-1:0] wspd;
        logic [6:0]                  rate;

        idle_out = mk_want(wtts_pkg::PH_EXIT, '0, 1'b0, 1'b0, '0, '0);
        torch    = 1'b0;

        // state straight out of reset, gating, zero reference on idle error
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000, 1, 1'b1, idle_out);
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b1, 12'hFFF, 1, 1'b1,
                 mk_want(wtts_pkg::PH_EXIT, '0, 1'b0, 1'b1, '0, '0));
        put_beat(wtts_pkg::CMD_TICK, 1'b1, 1'b1, 1'b0, 12'hABC, 1, 1'b1, idle_out);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b1, 12'hFFF, 1, 1'b1, idle_out);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b0, 1'b0, 12'h555, 1, 1'b1, idle_out);

        // four-step, no preflow, creep rate write masked to 127: saturated reference
        put_reg(wtts_pkg::CFG_TRIGGER_MODE, 8'(wtts_pkg::MODE_4T));
        put_reg(wtts_pkg::CFG_PREFLOW, 8'h00);
        put_reg(wtts_pkg::CFG_BURNBACK, 8'h00);
        put_reg(wtts_pkg::CFG_CREEP_RATE, 8'hFF);
        put_reg(wtts_pkg::CFG_CREEP_TIME, 8'hFF);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'hFFF, 1, 1'b1,
                 mk_want(wtts_pkg::PH_WELD,
                         wtts_pkg::FLAG_W'((1 << wtts_pkg::FL_GAS) |
                                           (1 << wtts_pkg::FL_PULSE)),
                         1'b1, 1'b1, wtts_pkg::REF_MAX, 12'd2550));
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // held: force off
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);   // first release
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // second press: crater
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);   // final release: burnback
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);   // into postflow
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // press aborts
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);

        // two-step with zero timers; spare register indexes must do nothing
        put_reg(wtts_pkg::CFG_TRIGGER_MODE, 8'(wtts_pkg::MODE_2T));
        put_reg(wtts_pkg::CFG_POSTFLOW, 8'h00);
        put_reg(wtts_pkg::CFG_CREEP_RATE, 8'd100);
        put_reg(CFG_SPARE_LO, 8'hFF);
        put_reg(CFG_SPARE_HI, 8'hFF);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // preflow done at once
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);   // burnback
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // press in burnback: exit
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000, 4);  // burn, post, off, idle

        // long preflow: early release keeps gas; ticks short of the limit
        put_reg(wtts_pkg::CFG_PREFLOW, 8'hFF);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000, 2);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);
        put_beat(wtts_pkg::CMD_TICK, 1'b1, 1'b1, 1'b0, 12'h000, 30);
        put_beat(wtts_pkg::CMD_EVAL, 1'b1, 1'b1, 1'b0, 12'h000);   // preflow still running
        put_beat(wtts_pkg::CMD_EVAL, 1'b0, 1'b1, 1'b0, 12'h000, 4);

        // reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int r = 0; r < dir_tab.size(); r++) begin
            if (dir_tab[r].kind == ROW_REG) begin
                if (r > 0 && dir_tab[r-1].kind == ROW_BEAT) drain_results();
                write_reg(dir_tab[r].idx, dir_tab[r].data,
                          r + 1 == dir_tab.size() || dir_tab[r+1].kind != ROW_REG);
            end else begin
                repeat (dir_tab[r].reps)
                    send_beat(dir_tab[r].cmd, dir_tab[r].pressed, dir_tab[r].gas,
                              dir_tab[r].gerr, dir_tab[r].wspd, dir_tab[r].typed,
                              dir_tab[r].want);
            end
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       rate = 7'd0;
                1:       rate = 7'd100;
                2:       rate = 7'd127;
                default: rate = 7'($urandom_range(0, 127));
            endcase
            write_reg(wtts_pkg::CFG_TRIGGER_MODE, 8'($urandom_range(0, 1)), 1'b0);
            write_reg(wtts_pkg::CFG_PREFLOW, pick_flow_time(), 1'b0);
            write_reg(wtts_pkg::CFG_BURNBACK, ($urandom_range(0, 15) == 0) ? 8'hFF :
                                              8'($urandom_range(0, 30)), 1'b0);
            write_reg(wtts_pkg::CFG_POSTFLOW, pick_flow_time(), 1'b0);
            write_reg(wtts_pkg::CFG_CREEP_RATE, {1'($urandom_range(0, 1)), rate}, 1'b0);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          8'($urandom), 1'b0);
            write_reg(wtts_pkg::CFG_CREEP_TIME, 8'($urandom_range(0, 255)), 1'b1);

            // torch held for random stretches, ticks mixed in, rare error / no gas
            repeat (BEATS_PER_PHASE) begin
                cmd = ($urandom_range(0, 9) < 4) ? wtts_pkg::CMD_TICK : wtts_pkg::CMD_EVAL;
                if (cmd == wtts_pkg::CMD_EVAL && $urandom_range(0, 3) == 0) torch = ~torch;
                case ($urandom_range(0, 7))
                    0:       wspd = '1;
                    1:       wspd = '0;
                    default: wspd = wtts_pkg::WIRE_W'($urandom);
                endcase
                send_beat(cmd, torch, $urandom_range(0, 15) != 0,
                          $urandom_range(0, 15) == 0, wspd, 1'b0, '0);
            end
        end

        // wait out the tail, bounded
        i_s_tvalid <= 1'b0;
        for (int k = 0; k < 2000 && pending_q.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wtts_pkg.sv
rtl/wtts_cfg_regs.sv
rtl/wtts_in_stage.sv
rtl/wtts_seq_core.sv
rtl/weld_torch_trigger_sequencer_unit.sv
test/weld_torch_trigger_sequencer_unit_test.sv
